/* rtl/core/i2c_register_access_sequencer_macros.svh */
// Assertion macros used by the checker file of the I2C register access sequencer.
`ifndef I2C_REGISTER_ACCESS_SEQUENCER_MACROS_SVH
`define I2C_REGISTER_ACCESS_SEQUENCER_MACROS_SVH

// A property that must hold whenever a result is offered.
`define RAS_ASSERT_ON_VALID(label, clk, rst_n, vld, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (vld) |-> (cond)) \
        else $error("result field check failed");

// A property that must hold in the cycle after a trigger.
`define RAS_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("next cycle check failed");

`endif

/* rtl/core/i2c_ras_pkg.sv */
// Package with the constants and codes of the I2C register access sequencer.
`timescale 1ns / 1ps

package i2c_ras_pkg;

    localparam int BUF_DEPTH = 256;
    localparam int BUF_AW    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

    typedef enum logic [2:0] {
        KIND_LOAD      = 3'd0,
        KIND_WRITE     = 3'd1,
        KIND_READ      = 3'd2,
        KIND_EVENT     = 3'd3,
        KIND_ACK_FAIL  = 3'd4
    } kind_t;

    localparam int ST_SB   = 0;
    localparam int ST_ADDR = 1;
    localparam int ST_MSL  = 2;
    localparam int ST_TRA  = 3;
    localparam int ST_TXE  = 4;
    localparam int ST_BTF  = 5;
    localparam int ST_RXNE = 6;

    localparam logic [1:0] CTL_KEEP    = 2'd0;
    localparam logic [1:0] CTL_ENABLE  = 2'd1;
    localparam logic [1:0] CTL_DISABLE = 2'd2;

    typedef struct packed {
        logic       send_valid;
        logic [7:0] send_byte;
        logic       send_from_buf;
        logic       gen_start;
        logic       gen_stop;
        logic [1:0] ack_control;
        logic [1:0] buffer_irq_control;
        logic [1:0] irq_control;
        logic       store_valid;
        logic [7:0] store_index;
        logic [7:0] store_byte;
        logic       noack_error;
    } result_t;

endpackage

/* rtl/core/i2c_register_access_sequencer.sv */
// I2C master register access sequencer: turns host commands and bus events into bus actions.
//
// The input channel (in_valid/in_ready) carries one item per transfer: a buffer load, a
// register write or read command, a bus status event or an acknowledge failure. Every
// accepted item yields exactly one result on the output channel (out_valid/out_ready),
// in order, with the bus actions to take and any received byte to store.
// From input transfer to result, the item is registered, decided against the sequencer
// state and the transmit buffer, and the result is registered. The sequencer takes one
// item per cycle while the receiver does not stall; the single-port buffer read for a
// transmit byte is issued in the decide cycle and its registered data joins the result.
// Reset clears the pipeline, the counters, the address bytes and the not-acknowledge
// flag. The data buffer is not cleared and holds nothing valid until loaded.
// When the receiver stalls, the whole pipeline holds and in_ready falls in the same
// cycle, so no result is lost; in_ready does not depend on in_valid.
`timescale 1ns / 1ps

module i2c_register_access_sequencer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] kind,
    input  logic [6:0] slave_addr,
    input  logic [7:0] reg_addr,
    input  logic [7:0] byte_count,
    input  logic [7:0] buf_index,
    input  logic [7:0] data_byte,
    input  logic [6:0] status_flags,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       send_valid,
    output logic [7:0] send_byte,
    output logic       gen_start,
    output logic       gen_stop,
    output logic [1:0] ack_control,
    output logic [1:0] buffer_irq_control,
    output logic [1:0] irq_control,
    output logic       store_valid,
    output logic [7:0] store_index,
    output logic [7:0] store_byte,
    output logic       noack_error
);

    logic       advance;

    logic       s1_valid_reg;
    logic [2:0] s1_kind_reg;
    logic [6:0] s1_slave_reg;
    logic [7:0] s1_reg_reg;
    logic [7:0] s1_cnt_reg;
    logic [7:0] s1_idx_reg;
    logic [7:0] s1_dat_reg;
    logic [6:0] s1_st_reg;

    logic       s2_valid_reg;
    i2c_ras_pkg::result_t s2_res_reg;
    i2c_ras_pkg::result_t res_next;

    logic [7:0] address_byte_reg,   address_byte_next;
    logic [7:0] register_byte_reg,  register_byte_next;
    logic [7:0] remaining_reg,      remaining_next;
    logic [7:0] position_reg,       position_next;
    logic [7:0] pending_reg,        pending_next;
    logic       noack_reg,          noack_next;

    logic [7:0] buf_mem [i2c_ras_pkg::BUF_DEPTH];
    logic [7:0] rdata_reg;
    logic       mem_we;
    logic [7:0] mem_waddr;
    logic [7:0] mem_wdata;
    logic       mem_re;
    logic [7:0] rem_dec;
    logic       pos_in_range;
    logic       widx_in_range;
    logic       tx_sel;
    logic       btf_sel;

    assign advance  = !s2_valid_reg || out_ready;
    assign in_ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_kind_reg  <= kind;
            s1_slave_reg <= slave_addr;
            s1_reg_reg   <= reg_addr;
            s1_cnt_reg   <= byte_count;
            s1_idx_reg   <= buf_index;
            s1_dat_reg   <= data_byte;
            s1_st_reg    <= status_flags;
            s2_res_reg   <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            address_byte_reg  <= 8'd0;
            register_byte_reg <= 8'd0;
            remaining_reg     <= 8'd0;
            position_reg      <= 8'd0;
            pending_reg       <= 8'd0;
            noack_reg         <= 1'b0;
        end
        else if (advance && s1_valid_reg)
        begin
            address_byte_reg  <= address_byte_next;
            register_byte_reg <= register_byte_next;
            remaining_reg     <= remaining_next;
            position_reg      <= position_next;
            pending_reg       <= pending_next;
            noack_reg         <= noack_next;
        end
    end

    assign pos_in_range  = ({1'b0, position_reg} < 9'(i2c_ras_pkg::BUF_DEPTH));
    assign widx_in_range = ({1'b0, mem_waddr} < 9'(i2c_ras_pkg::BUF_DEPTH));
    assign rem_dec       = remaining_reg - 8'd1;
    assign tx_sel        = s1_st_reg[i2c_ras_pkg::ST_TXE] && !s1_st_reg[i2c_ras_pkg::ST_BTF];
    assign btf_sel       = s1_st_reg[i2c_ras_pkg::ST_TXE] && s1_st_reg[i2c_ras_pkg::ST_BTF];

    always_comb
    begin
        address_byte_next  = address_byte_reg;
        register_byte_next = register_byte_reg;
        remaining_next     = remaining_reg;
        position_next      = position_reg;
        pending_next       = pending_reg;
        noack_next         = noack_reg;
        res_next           = '0;
        mem_we             = 1'b0;
        mem_waddr          = s1_idx_reg;
        mem_wdata          = s1_dat_reg;
        mem_re             = 1'b0;

        unique case (s1_kind_reg) inside
            i2c_ras_pkg::KIND_LOAD:
            begin
                mem_we = s1_valid_reg;
            end
            i2c_ras_pkg::KIND_WRITE, i2c_ras_pkg::KIND_READ:
            begin
                address_byte_next  = {s1_slave_reg, 1'b0};
                register_byte_next = s1_reg_reg;
                position_next      = 8'd0;
                if (s1_kind_reg == i2c_ras_pkg::KIND_WRITE)
                begin
                    remaining_next = s1_cnt_reg;
                    pending_next   = 8'd0;
                end
                else
                begin
                    remaining_next       = 8'd0;
                    pending_next         = s1_cnt_reg;
                    res_next.ack_control = i2c_ras_pkg::CTL_ENABLE;
                end
                res_next.irq_control = i2c_ras_pkg::CTL_ENABLE;
                res_next.gen_start   = 1'b1;
            end
            i2c_ras_pkg::KIND_EVENT:
            begin
                if (s1_st_reg[i2c_ras_pkg::ST_SB])
                begin
                    res_next.send_valid = 1'b1;
                    res_next.send_byte  = address_byte_reg;
                end
                else if (!s1_st_reg[i2c_ras_pkg::ST_MSL])
                begin
                    res_next.send_valid = 1'b0;
                end
                else if (s1_st_reg[i2c_ras_pkg::ST_ADDR])
                begin
                    if (s1_st_reg[i2c_ras_pkg::ST_TRA])
                    begin
                        res_next.send_valid = 1'b1;
                        res_next.send_byte  = register_byte_reg;
                        if (remaining_reg == 8'd0)
                        begin
                            res_next.buffer_irq_control = i2c_ras_pkg::CTL_DISABLE;
                        end
                    end
                    else
                    begin
                        position_next = 8'd0;
                        if (remaining_reg == 8'd1)
                        begin
                            res_next.ack_control = i2c_ras_pkg::CTL_DISABLE;
                            res_next.gen_stop    = 1'b1;
                        end
                    end
                end
                else if (tx_sel)
                begin
                    if (remaining_reg != 8'd0)
                    begin
                        res_next.send_valid    = 1'b1;
                        res_next.send_from_buf = pos_in_range;
                        mem_re                 = s1_valid_reg && pos_in_range;
                        position_next          = position_reg + 8'd1;
                        remaining_next         = rem_dec;
                        if (rem_dec == 8'd0)
                        begin
                            res_next.buffer_irq_control = i2c_ras_pkg::CTL_DISABLE;
                        end
                    end
                end
                else if (btf_sel)
                begin
                    if (pending_reg != 8'd0)
                    begin
                        remaining_next              = pending_reg;
                        pending_next                = 8'd0;
                        address_byte_next           = address_byte_reg + 8'd1;
                        res_next.buffer_irq_control = i2c_ras_pkg::CTL_ENABLE;
                        res_next.gen_start          = 1'b1;
                        res_next.send_valid         = 1'b1;
                    end
                    else
                    begin
                        res_next.gen_stop    = 1'b1;
                        res_next.irq_control = i2c_ras_pkg::CTL_DISABLE;
                    end
                end
                else if (s1_st_reg[i2c_ras_pkg::ST_RXNE])
                begin
                    mem_we               = s1_valid_reg;
                    mem_waddr            = position_reg;
                    res_next.store_valid = 1'b1;
                    res_next.store_index = position_reg;
                    res_next.store_byte  = s1_dat_reg;
                    position_next        = position_reg + 8'd1;
                    remaining_next       = rem_dec;
                    if (rem_dec == 8'd1)
                    begin
                        res_next.ack_control = i2c_ras_pkg::CTL_DISABLE;
                        res_next.gen_stop    = 1'b1;
                    end
                end
            end
            i2c_ras_pkg::KIND_ACK_FAIL:
            begin
                noack_next = 1'b1;
            end
            default:
            begin
                res_next.send_valid = 1'b0;
            end
        endcase

        res_next.noack_error = noack_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && mem_we && widx_in_range)
        begin
            buf_mem[mem_waddr[i2c_ras_pkg::BUF_AW-1:0]] <= mem_wdata;
        end
        if (advance && mem_re)
        begin
            rdata_reg <= buf_mem[position_reg[i2c_ras_pkg::BUF_AW-1:0]];
        end
    end

    assign out_valid          = s2_valid_reg;
    assign send_valid         = s2_res_reg.send_valid;
    assign send_byte          = s2_res_reg.send_from_buf ? rdata_reg : s2_res_reg.send_byte;
    assign gen_start          = s2_res_reg.gen_start;
    assign gen_stop           = s2_res_reg.gen_stop;
    assign ack_control        = s2_res_reg.ack_control;
    assign buffer_irq_control = s2_res_reg.buffer_irq_control;
    assign irq_control        = s2_res_reg.irq_control;
    assign store_valid        = s2_res_reg.store_valid;
    assign store_index        = s2_res_reg.store_index;
    assign store_byte         = s2_res_reg.store_byte;
    assign noack_error        = s2_res_reg.noack_error;

endmodule

/* rtl/core/i2c_ras_checker.sv */
// Port-level checker for the I2C register access sequencer and its bind statement.
`timescale 1ns / 1ps
`include "i2c_register_access_sequencer_macros.svh"

module i2c_ras_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       send_valid,
    input logic [7:0] send_byte,
    input logic       gen_start,
    input logic       gen_stop,
    input logic [1:0] ack_control,
    input logic [1:0] buffer_irq_control,
    input logic [1:0] irq_control,
    input logic       store_valid,
    input logic [7:0] store_index,
    input logic [7:0] store_byte
);

    logic       stalled;
    logic [8:0] send_word;
    logic       codes_ok;
    logic       store_idle_ok;

    assign stalled       = out_valid && !out_ready;
    assign send_word     = {send_valid, send_byte};
    assign codes_ok      = (ack_control != 2'd3) && (buffer_irq_control != 2'd3)
                           && (irq_control != 2'd3);
    assign store_idle_ok = store_valid || (store_index == 8'd0 && store_byte == 8'd0);

    // A stalled result must keep its transmit action.
    `RAS_ASSERT_NEXT(a_stall_hold, clk, rst_n, stalled, out_valid && $stable(send_word))

    // A result never asks for a start and a stop at once.
    `RAS_ASSERT_ON_VALID(a_start_stop, clk, rst_n, out_valid, !(gen_start && gen_stop))

    // A result either transmits a byte or stores one, never both.
    `RAS_ASSERT_ON_VALID(a_send_store, clk, rst_n, out_valid, !(send_valid && store_valid))

    // Control codes stay within their defined range, and idle store fields read zero.
    `RAS_ASSERT_ON_VALID(a_ctl_codes, clk, rst_n, out_valid, codes_ok && store_idle_ok)

endmodule

bind i2c_register_access_sequencer i2c_ras_checker u_i2c_ras_checker (.*);
